@@ src/mmx_pkg.sv @@
// ---------------------------------------------------------------------------
// mmx_pkg: shared types and constants of the multirotor motor mixer
// Holds the configuration register map, the per-frame motor counts and the
// mixing weight table (roll, pitch, yaw weight codes per motor).
// ---------------------------------------------------------------------------
package mmx_pkg;

  localparam int MOTOR_COUNT_MAX_DEF = 8;
  localparam int COEF_FRAC_BITS_DEF  = 14;

  localparam int FRAME_COUNT = 12;
  localparam int ROM_MOTORS  = 8;
  localparam int IN_W        = 16;
  localparam int STICK_W     = 12;
  localparam int VAL_W       = 12;
  localparam int FRAME_W     = 4;
  localparam int CNT_W       = 4;
  localparam int IDX_OUT_W   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int SCR_W       = 18;
  localparam int YAW_W       = 17;

  // axis slots of the weight table
  localparam int AX_ROLL  = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_YAW   = 2;
  localparam int AX_COUNT = 3;

  // weights in millionths
  localparam longint MICRO_43  = 1333333;
  localparam longint MICRO_23  = 666667;
  localparam longint MICRO_S32 = 866025;
  localparam longint MICRO_R22 = 707107;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_TYPE,
    CFG_YAW_REVERSE,
    CFG_MIN_THROTTLE,
    CFG_MAX_THROTTLE,
    CFG_MIN_COMMAND,
    CFG_MIN_CHECK,
    CFG_MOTOR_STOP
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MAG_ZERO,
    MAG_ONE,
    MAG_HF,
    MAG_43,
    MAG_23,
    MAG_S32,
    MAG_R22
  } mag_e;

  typedef struct packed {
    logic neg;
    mag_e mag;
  } wcode_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_type;
    logic               yaw_reverse;
    logic [VAL_W-1:0]   min_throttle;
    logic [VAL_W-1:0]   max_throttle;
    logic [VAL_W-1:0]   min_command;
    logic [VAL_W-1:0]   min_check;
    logic               motor_stop;
    logic [CNT_W-1:0]   motors;
  } cfg_t;

  typedef struct packed {
    logic armed;
    logic low_stick;
  } item_flags_t;

  localparam wcode_t W_Z   = '{neg: 1'b0, mag: MAG_ZERO};
  localparam wcode_t W_P1  = '{neg: 1'b0, mag: MAG_ONE};
  localparam wcode_t W_N1  = '{neg: 1'b1, mag: MAG_ONE};
  localparam wcode_t W_P43 = '{neg: 1'b0, mag: MAG_43};
  localparam wcode_t W_N23 = '{neg: 1'b1, mag: MAG_23};
  localparam wcode_t W_PS  = '{neg: 1'b0, mag: MAG_S32};
  localparam wcode_t W_NS  = '{neg: 1'b1, mag: MAG_S32};
  localparam wcode_t W_PR  = '{neg: 1'b0, mag: MAG_R22};
  localparam wcode_t W_NR  = '{neg: 1'b1, mag: MAG_R22};
  localparam wcode_t W_PH  = '{neg: 1'b0, mag: MAG_HF};
  localparam wcode_t W_NH  = '{neg: 1'b1, mag: MAG_HF};

  localparam logic [CNT_W-1:0] FRAME_MOTORS [FRAME_COUNT] = '{
    4'd3, 4'd4, 4'd4, 4'd2, 4'd6, 4'd6, 4'd4, 4'd6, 4'd8, 4'd8, 4'd8, 4'd4
  };

  // roll, pitch, yaw weight per motor; throttle weight is always one
  localparam wcode_t MIX_ROM [FRAME_COUNT][ROM_MOTORS][AX_COUNT] = '{
    // tri
    '{'{W_Z, W_P43, W_Z}, '{W_N1, W_N23, W_Z}, '{W_P1, W_N23, W_Z}, '{W_Z, W_Z, W_Z},
      '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}},
    // quad plus
    '{'{W_Z, W_P1, W_N1}, '{W_N1, W_Z, W_P1}, '{W_P1, W_Z, W_P1}, '{W_Z, W_N1, W_N1},
      '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}},
    // quad x
    '{'{W_N1, W_P1, W_N1}, '{W_N1, W_N1, W_P1}, '{W_P1, W_P1, W_P1}, '{W_P1, W_N1, W_N1},
      '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}},
    // bi
    '{'{W_P1, W_Z, W_Z}, '{W_N1, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z},
      '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}},
    // y6
    '{'{W_Z, W_P43, W_P1}, '{W_N1, W_N23, W_N1}, '{W_P1, W_N23, W_N1}, '{W_Z, W_P43, W_N1},
      '{W_N1, W_N23, W_P1}, '{W_P1, W_N23, W_P1}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}},
    // hex6
    '{'{W_N1, W_PS, W_P1}, '{W_N1, W_NS, W_N1}, '{W_P1, W_PS, W_P1}, '{W_P1, W_NS, W_N1},
      '{W_Z, W_PS, W_P1}, '{W_Z, W_NS, W_N1}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}},
    // y4
    '{'{W_Z, W_P1, W_N1}, '{W_N1, W_N1, W_Z}, '{W_Z, W_P1, W_P1}, '{W_P1, W_N1, W_Z},
      '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}},
    // hex6 x
    '{'{W_NS, W_P1, W_P1}, '{W_NS, W_N1, W_P1}, '{W_PS, W_P1, W_N1}, '{W_PS, W_N1, W_N1},
      '{W_NS, W_Z, W_N1}, '{W_PS, W_Z, W_P1}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}},
    // octo x8
    '{'{W_N1, W_P1, W_N1}, '{W_N1, W_N1, W_P1}, '{W_P1, W_P1, W_P1}, '{W_P1, W_N1, W_N1},
      '{W_N1, W_P1, W_P1}, '{W_N1, W_N1, W_N1}, '{W_P1, W_P1, W_N1}, '{W_P1, W_N1, W_P1}},
    // octo flat plus
    '{'{W_PR, W_NR, W_P1}, '{W_NR, W_NR, W_P1}, '{W_NR, W_PR, W_P1}, '{W_PR, W_PR, W_P1},
      '{W_Z, W_N1, W_N1}, '{W_N1, W_Z, W_N1}, '{W_Z, W_P1, W_N1}, '{W_P1, W_Z, W_N1}},
    // octo flat x
    '{'{W_P1, W_NH, W_P1}, '{W_NH, W_N1, W_P1}, '{W_N1, W_PH, W_P1}, '{W_PH, W_P1, W_P1},
      '{W_PH, W_N1, W_N1}, '{W_N1, W_NH, W_N1}, '{W_NH, W_P1, W_N1}, '{W_P1, W_PH, W_N1}},
    // vtail4
    '{'{W_Z, W_P1, W_P1}, '{W_N1, W_N1, W_Z}, '{W_Z, W_P1, W_N1}, '{W_P1, W_N1, W_Z},
      '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}, '{W_Z, W_Z, W_Z}}
  };

  // weight in fixed point, rounded to nearest, ties away from zero
  function automatic longint q_weight(input longint micro, input int fbits);
    return (micro * (longint'(1) << fbits) + 64'sd500000) / 64'sd1000000;
  endfunction

endpackage

@@ src/mmx_cfg.sv @@
// ---------------------------------------------------------------------------
// mmx_cfg: configuration registers
// Write-only register file and the active motor count of the chosen frame.
// ---------------------------------------------------------------------------
module mmx_cfg #(
  parameter int MotorCountMax = mmx_pkg::MOTOR_COUNT_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mmx_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mmx_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output mmx_pkg::cfg_t                    cfg_o
);
  import mmx_pkg::*;

  logic [FRAME_W-1:0] frame_q;
  logic               yaw_rev_q;
  logic [VAL_W-1:0]   min_thr_q;
  logic [VAL_W-1:0]   max_thr_q;
  logic [VAL_W-1:0]   min_cmd_q;
  logic [VAL_W-1:0]   min_chk_q;
  logic               stop_q;
  logic [CNT_W-1:0]   motors;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q   <= FRAME_W'(2);
      yaw_rev_q <= 1'b0;
      min_thr_q <= VAL_W'(1150);
      max_thr_q <= VAL_W'(1850);
      min_cmd_q <= VAL_W'(1000);
      min_chk_q <= VAL_W'(1100);
      stop_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_TYPE:   frame_q   <= cfg_wdata_i[FRAME_W-1:0];
        CFG_YAW_REVERSE:  yaw_rev_q <= cfg_wdata_i[0];
        CFG_MIN_THROTTLE: min_thr_q <= cfg_wdata_i[VAL_W-1:0];
        CFG_MAX_THROTTLE: max_thr_q <= cfg_wdata_i[VAL_W-1:0];
        CFG_MIN_COMMAND:  min_cmd_q <= cfg_wdata_i[VAL_W-1:0];
        CFG_MIN_CHECK:    min_chk_q <= cfg_wdata_i[VAL_W-1:0];
        CFG_MOTOR_STOP:   stop_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // unknown frames have no motors; large frames are cut to the lane count
  always_comb begin
    if (frame_q >= FRAME_W'(FRAME_COUNT)) begin
      motors = '0;
    end else if (FRAME_MOTORS[frame_q] > CNT_W'(MotorCountMax)) begin
      motors = CNT_W'(MotorCountMax);
    end else begin
      motors = FRAME_MOTORS[frame_q];
    end
  end

  assign cfg_o = '{
    frame_type:   frame_q,
    yaw_reverse:  yaw_rev_q,
    min_throttle: min_thr_q,
    max_throttle: max_thr_q,
    min_command:  min_cmd_q,
    min_check:    min_chk_q,
    motor_stop:   stop_q,
    motors:       motors
  };

endmodule

@@ src/mmx_mix.sv @@
// ---------------------------------------------------------------------------
// mmx_mix: mixing pipeline
// Input register, yaw clamp and constant products, per-motor weighted sums,
// truncation toward zero and saturation into the motor scratch registers.
// ---------------------------------------------------------------------------
module mmx_mix #(
  parameter int MotorCountMax = mmx_pkg::MOTOR_COUNT_MAX_DEF,
  parameter int CoefFracBits  = mmx_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mmx_pkg::cfg_t                         cfg_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [mmx_pkg::IN_W-1:0]       throttle_cmd_i,
  input  logic signed [mmx_pkg::IN_W-1:0]       pid_roll_i,
  input  logic signed [mmx_pkg::IN_W-1:0]       pid_pitch_i,
  input  logic signed [mmx_pkg::IN_W-1:0]       pid_yaw_i,
  input  logic signed [mmx_pkg::IN_W-1:0]       yaw_cmd_i,
  input  logic [mmx_pkg::STICK_W-1:0]           stick_throttle_i,
  input  logic                                  armed_i,
  output logic                                  dn_valid_o,
  input  logic                                  dn_ready_i,
  output mmx_pkg::item_flags_t                  dn_flags_o,
  output logic signed [mmx_pkg::SCR_W-1:0]      dn_scr_o [MotorCountMax]
);
  import mmx_pkg::*;

  localparam int AW = CoefFracBits + 19;
  localparam int TW = AW - CoefFracBits;

  localparam logic signed [AW-1:0] Q_43  = AW'(q_weight(MICRO_43, CoefFracBits));
  localparam logic signed [AW-1:0] Q_23  = AW'(q_weight(MICRO_23, CoefFracBits));
  localparam logic signed [AW-1:0] Q_S32 = AW'(q_weight(MICRO_S32, CoefFracBits));
  localparam logic signed [AW-1:0] Q_R22 = AW'(q_weight(MICRO_R22, CoefFracBits));
  localparam logic signed [AW-1:0] TRUNC_BIAS = AW'((longint'(1) << CoefFracBits) - 1);
  localparam logic signed [TW-1:0] SAT_HI = TW'((1 << (SCR_W - 1)) - 1);
  localparam logic signed [TW-1:0] SAT_LO = -TW'(1 << (SCR_W - 1));

  function automatic logic signed [AW-1:0] term(
    input wcode_t                 w,
    input logic signed [AW-1:0]   x,
    input logic signed [AW-1:0]   p43,
    input logic signed [AW-1:0]   p23,
    input logic signed [AW-1:0]   ps,
    input logic signed [AW-1:0]   pr
  );
    logic signed [AW-1:0] m;
    case (w.mag)
      MAG_ZERO: m = '0;
      MAG_ONE:  m = x <<< CoefFracBits;
      MAG_HF:   m = x <<< (CoefFracBits - 1);
      MAG_43:   m = p43;
      MAG_23:   m = p23;
      MAG_S32:  m = ps;
      MAG_R22:  m = pr;
      default:  m = '0;
    endcase
    return w.neg ? -m : m;
  endfunction

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: input register
  logic signed [IN_W-1:0] thr1_q, roll1_q, pitch1_q, yaw1_q, ycmd1_q;
  item_flags_t            flags1_q;

  // stage 2: clamped yaw and constant products
  logic signed [IN_W-1:0]  thr2_q, roll2_q, pitch2_q;
  logic signed [YAW_W-1:0] yaw2_q;
  logic signed [AW-1:0]    roll_s32_q, roll_r22_q;
  logic signed [AW-1:0]    pitch_43_q, pitch_23_q, pitch_s32_q, pitch_r22_q;
  item_flags_t             flags2_q;

  // stage 3: weighted sums
  logic signed [AW-1:0] acc3_q [MotorCountMax];
  item_flags_t          flags3_q;

  // stage 4: motor scratch
  logic signed [SCR_W-1:0] scr4_q [MotorCountMax];
  item_flags_t             flags4_q;

  assign rdy4 = !v4_q || dn_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      // drop items of a frame without motors right at the input
      if (rdy1) v1_q <= in_valid_i && (cfg_i.motors != '0);
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      thr1_q             <= throttle_cmd_i;
      roll1_q            <= pid_roll_i;
      pitch1_q           <= pid_pitch_i;
      yaw1_q             <= pid_yaw_i;
      ycmd1_q            <= yaw_cmd_i;
      flags1_q.armed     <= armed_i;
      flags1_q.low_stick <= stick_throttle_i < cfg_i.min_check;
    end
  end

  // stage 1 -> 2
  logic signed [YAW_W:0] ycmd_w, yaw_w, lim, yaw_c, yaw_f;
  logic signed [AW-1:0]  rx, px;

  always_comb begin
    ycmd_w = (YAW_W + 1)'(ycmd1_q);
    yaw_w  = (YAW_W + 1)'(yaw1_q);
    lim    = (YAW_W + 1)'(100) + ((ycmd_w < 0) ? -ycmd_w : ycmd_w);
    yaw_c  = yaw_w;
    if (cfg_i.motors > CNT_W'(3)) begin
      if (yaw_w < -lim) begin
        yaw_c = -lim;
      end else if (yaw_w > lim) begin
        yaw_c = lim;
      end
    end
    yaw_f = cfg_i.yaw_reverse ? -yaw_c : yaw_c;
    rx    = AW'(roll1_q);
    px    = AW'(pitch1_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      thr2_q      <= thr1_q;
      roll2_q     <= roll1_q;
      pitch2_q    <= pitch1_q;
      yaw2_q      <= YAW_W'(yaw_f);
      roll_s32_q  <= AW'(rx * Q_S32);
      roll_r22_q  <= AW'(rx * Q_R22);
      pitch_43_q  <= AW'(px * Q_43);
      pitch_23_q  <= AW'(px * Q_23);
      pitch_s32_q <= AW'(px * Q_S32);
      pitch_r22_q <= AW'(px * Q_R22);
      flags2_q    <= flags1_q;
    end
  end

  // stage 2 -> 3
  logic [FRAME_W-1:0]   fsel;
  logic signed [AW-1:0] acc_d [MotorCountMax];

  always_comb begin
    fsel = (cfg_i.frame_type < FRAME_W'(FRAME_COUNT)) ? cfg_i.frame_type : '0;
    for (int i = 0; i < MotorCountMax; i++) begin
      acc_d[i] = (AW'(thr2_q) <<< CoefFracBits)
               + term(MIX_ROM[fsel][i][AX_ROLL], AW'(roll2_q), '0, '0,
                      roll_s32_q, roll_r22_q)
               + term(MIX_ROM[fsel][i][AX_PITCH], AW'(pitch2_q), pitch_43_q,
                      pitch_23_q, pitch_s32_q, pitch_r22_q)
               + term(MIX_ROM[fsel][i][AX_YAW], AW'(yaw2_q), '0, '0, '0, '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      acc3_q   <= acc_d;
      flags3_q <= flags2_q;
    end
  end

  // stage 3 -> 4: truncate toward zero, saturate to the scratch width
  logic signed [AW-1:0]    biased [MotorCountMax];
  logic signed [TW-1:0]    trunc  [MotorCountMax];
  logic signed [SCR_W-1:0] scr_d  [MotorCountMax];

  always_comb begin
    for (int i = 0; i < MotorCountMax; i++) begin
      biased[i] = acc3_q[i] + (acc3_q[i][AW-1] ? TRUNC_BIAS : '0);
      trunc[i]  = TW'(biased[i] >>> CoefFracBits);
      if (trunc[i] > SAT_HI) begin
        scr_d[i] = SCR_W'(SAT_HI);
      end else if (trunc[i] < SAT_LO) begin
        scr_d[i] = SCR_W'(SAT_LO);
      end else begin
        scr_d[i] = SCR_W'(trunc[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      scr4_q   <= scr_d;
      flags4_q <= flags3_q;
    end
  end

  assign dn_valid_o = v4_q;
  assign dn_flags_o = flags4_q;
  assign dn_scr_o   = scr4_q;

endmodule

@@ src/mmx_emit.sv @@
// ---------------------------------------------------------------------------
// mmx_emit: desaturation and motor sequencer
// Takes the largest motor sum on entry, then walks the motors one per cycle
// when not stalled: shifts, clamps and applies low-stick and disarm overrides.
// ---------------------------------------------------------------------------
module mmx_emit #(
  parameter int MotorCountMax = mmx_pkg::MOTOR_COUNT_MAX_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mmx_pkg::cfg_t                        cfg_i,
  input  logic                                 up_valid_i,
  output logic                                 up_ready_o,
  input  mmx_pkg::item_flags_t                 up_flags_i,
  input  logic signed [mmx_pkg::SCR_W-1:0]     up_scr_i [MotorCountMax],
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mmx_pkg::IDX_OUT_W-1:0]        motor_index_o,
  output logic [mmx_pkg::VAL_W-1:0]            motor_value_o,
  output logic                                 last_o
);
  import mmx_pkg::*;

  localparam int IW = $clog2(MotorCountMax);
  localparam int VW = SCR_W + 2;
  localparam logic signed [SCR_W-1:0] SCR_MIN = -SCR_W'(1 << (SCR_W - 1));

  logic                    v5_q;
  logic signed [SCR_W-1:0] scr5_q [MotorCountMax];
  logic signed [SCR_W-1:0] max5_q;
  item_flags_t             flags5_q;
  logic [IW-1:0]           idx_q;

  logic                  ovalid_q;
  logic [IDX_OUT_W-1:0]  oidx_q;
  logic [VAL_W-1:0]      oval_q;
  logic                  olast_q;

  // largest sum over the motors in use
  logic signed [SCR_W-1:0] max_d;

  always_comb begin
    max_d = SCR_MIN;
    for (int i = 0; i < MotorCountMax; i++) begin
      if (CNT_W'(i) < cfg_i.motors && up_scr_i[i] > max_d) begin
        max_d = up_scr_i[i];
      end
    end
  end

  logic out_rdy, emit, is_last;

  assign out_rdy    = !ovalid_q || !out_stall_i;
  assign emit       = v5_q && out_rdy;
  assign is_last    = CNT_W'(idx_q) == (cfg_i.motors - CNT_W'(1));
  assign up_ready_o = !v5_q || (out_rdy && is_last);

  // value of the motor under the sequencer
  logic signed [VW-1:0] cur, mn_s, mx_s, shifted;
  logic [VAL_W-1:0]     val;

  always_comb begin
    cur  = VW'(scr5_q[idx_q]);
    mn_s = VW'(signed'({1'b0, cfg_i.min_throttle}));
    mx_s = VW'(signed'({1'b0, cfg_i.max_throttle}));
    shifted = cur;
    if (VW'(max5_q) > mx_s) begin
      shifted = cur - VW'(max5_q) + mx_s;
    end
    if (shifted < mn_s) begin
      val = cfg_i.min_throttle;
    end else if (shifted > mx_s) begin
      val = cfg_i.max_throttle;
    end else begin
      val = shifted[VAL_W-1:0];
    end
    if (flags5_q.low_stick) begin
      val = cfg_i.motor_stop ? cfg_i.min_command : cfg_i.min_throttle;
    end
    if (!flags5_q.armed) begin
      val = cfg_i.min_command;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q     <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (up_ready_o) v5_q <= up_valid_i;
      if (emit) idx_q <= is_last ? '0 : idx_q + IW'(1);
      if (out_rdy) ovalid_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      scr5_q   <= up_scr_i;
      max5_q   <= max_d;
      flags5_q <= up_flags_i;
    end
    if (emit) begin
      oidx_q  <= IDX_OUT_W'(idx_q);
      oval_q  <= val;
      olast_q <= is_last;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign motor_index_o = oidx_q;
  assign motor_value_o = oval_q;
  assign last_o        = olast_q;

endmodule

@@ src/multirotor_motor_mixer_unit.sv @@
// ---------------------------------------------------------------------------
// multirotor_motor_mixer_unit: multirotor motor mixing matrix
// Path: input, product, sum, scratch, sequencer and output registers in turn.
// Throughput: one result per cycle while the output is not stalled; an item
// yields one result per frame motor (2 to 8) on the single sequencer port.
// Reset: configuration registers take their defaults (quad x), pipeline empty.
// ---------------------------------------------------------------------------
module multirotor_motor_mixer_unit #(
  parameter int MOTOR_COUNT_MAX = mmx_pkg::MOTOR_COUNT_MAX_DEF,
  parameter int COEF_FRAC_BITS  = mmx_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mmx_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mmx_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [mmx_pkg::IN_W-1:0]     throttle_cmd_i,
  input  logic signed [mmx_pkg::IN_W-1:0]     pid_roll_i,
  input  logic signed [mmx_pkg::IN_W-1:0]     pid_pitch_i,
  input  logic signed [mmx_pkg::IN_W-1:0]     pid_yaw_i,
  input  logic signed [mmx_pkg::IN_W-1:0]     yaw_cmd_i,
  input  logic [mmx_pkg::STICK_W-1:0]         stick_throttle_i,
  input  logic                                armed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mmx_pkg::IDX_OUT_W-1:0]       motor_index_o,
  output logic [mmx_pkg::VAL_W-1:0]           motor_value_o,
  output logic                                last_o
);
  import mmx_pkg::*;

  cfg_t                    cfg;
  logic                    mix_valid, mix_ready;
  item_flags_t             mix_flags;
  logic signed [SCR_W-1:0] mix_scr [MOTOR_COUNT_MAX];

  mmx_cfg #(
    .MotorCountMax(MOTOR_COUNT_MAX)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  mmx_mix #(
    .MotorCountMax(MOTOR_COUNT_MAX),
    .CoefFracBits (COEF_FRAC_BITS)
  ) u_mix (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .throttle_cmd_i  (throttle_cmd_i),
    .pid_roll_i      (pid_roll_i),
    .pid_pitch_i     (pid_pitch_i),
    .pid_yaw_i       (pid_yaw_i),
    .yaw_cmd_i       (yaw_cmd_i),
    .stick_throttle_i(stick_throttle_i),
    .armed_i         (armed_i),
    .dn_valid_o      (mix_valid),
    .dn_ready_i      (mix_ready),
    .dn_flags_o      (mix_flags),
    .dn_scr_o        (mix_scr)
  );

  mmx_emit #(
    .MotorCountMax(MOTOR_COUNT_MAX)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .up_valid_i   (mix_valid),
    .up_ready_o   (mix_ready),
    .up_flags_i   (mix_flags),
    .up_scr_i     (mix_scr),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .motor_index_o(motor_index_o),
    .motor_value_o(motor_value_o),
    .last_o       (last_o)
  );

  // a taken result that is not the last of its item is followed at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("motor sequence broke off before its last motor");

  // the motor index advances on every taken non-last result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> motor_index_o != $past(motor_index_o))
    else $error("motor index did not advance");

  // the next item starts again at motor zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o || motor_index_o == '0)
    else $error("new item did not start at motor zero");

endmodule

@@ tb/multirotor_motor_mixer_unit_tb.sv @@
// ---------------------------------------------------------------------------
// multirotor_motor_mixer_unit_tb: self-checking bench for the motor mixer
// Feeds control cycles through the valid/stall input and predicts every
// motor command in the bench. Checks each accepted result against the oldest
// prediction. Register settings change only while the mixer is idle. The run
// covers every frame, the throttle range extremes and unknown frames. It
// adds random gaps and output back-pressure, and two long output hold-offs.
// ---------------------------------------------------------------------------
module multirotor_motor_mixer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmx_pkg::*;

  localparam int FRAC          = COEF_FRAC_BITS_DEF;
  localparam int MOTORS_MAX    = MOTOR_COUNT_MAX_DEF;
  localparam int SUM_MAX       = 131071;
  localparam int SUM_MIN       = -131072;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 80;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PRINT_LIMIT   = 40;

  // weights in millionths
  localparam int U   = 1000000;
  localparam int P43 = 1333333;
  localparam int N23 = -666667;
  localparam int S32 = 866025;
  localparam int R22 = 707107;
  localparam int HF  = 500000;

  typedef struct {
    logic signed [IN_W-1:0] throttle;
    logic signed [IN_W-1:0] roll;
    logic signed [IN_W-1:0] pitch;
    logic signed [IN_W-1:0] yaw;
    logic signed [IN_W-1:0] ycmd;
    logic [STICK_W-1:0]     stick;
    logic                   armed;
  } ctrl_item_t;

  typedef struct {
    logic [IDX_OUT_W-1:0] index;
    logic [VAL_W-1:0]     value;
    logic                 last;
  } motor_cmd_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [IN_W-1:0] throttle_cmd_i = '0;
  logic signed [IN_W-1:0] pid_roll_i = '0;
  logic signed [IN_W-1:0] pid_pitch_i = '0;
  logic signed [IN_W-1:0] pid_yaw_i = '0;
  logic signed [IN_W-1:0] yaw_cmd_i = '0;
  logic [STICK_W-1:0]     stick_throttle_i = '0;
  logic                   armed_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [IDX_OUT_W-1:0]   motor_index_o;
  logic [VAL_W-1:0]       motor_value_o;
  logic                   last_o;

  multirotor_motor_mixer_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .throttle_cmd_i   (throttle_cmd_i),
    .pid_roll_i       (pid_roll_i),
    .pid_pitch_i      (pid_pitch_i),
    .pid_yaw_i        (pid_yaw_i),
    .yaw_cmd_i        (yaw_cmd_i),
    .stick_throttle_i (stick_throttle_i),
    .armed_i          (armed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .motor_index_o    (motor_index_o),
    .motor_value_o    (motor_value_o),
    .last_o           (last_o)
  );

  // mixer settings as the bench sees them
  int unsigned sh_frame = 2;
  bit          sh_yaw_rev = 1'b0;
  int          sh_min_thr = 1150;
  int          sh_max_thr = 1850;
  int          sh_min_cmd = 1000;
  int          sh_min_check = 1100;
  bit          sh_stop = 1'b0;

  // roll, pitch, yaw weight per frame and motor; throttle weight is one
  int mix_micro [FRAME_COUNT][MOTORS_MAX][3];
  int frame_motors [FRAME_COUNT];

  ctrl_item_t ctrl_backlog [$];
  motor_cmd_t expected_motor_cmds [$];

  ctrl_item_t  tx_cur;
  bit          tx_loaded = 1'b0;
  int          tx_gap = 0;
  bit          tx_idle_on = 1'b1;
  int          rx_hold = 0;
  bit          rx_idle_on = 1'b1;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          cycle_count = 0;
  int          errors = 0;
  int          items_in = 0;
  int          results_seen = 0;
  int          settings_run = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_motor_cmds.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_LIMIT) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    end
    errors++;
  endtask

  function automatic longint to_fixed(input int micro);
    longint mag;
    mag = (micro < 0) ? -longint'(micro) : longint'(micro);
    mag = (mag * (longint'(1) << FRAC) + U / 2) / U;
    return (micro < 0) ? -mag : mag;
  endfunction

  task automatic add_motor(input int frame, input int roll, input int pitch, input int yaw);
    mix_micro[frame][frame_motors[frame]][0] = roll;
    mix_micro[frame][frame_motors[frame]][1] = pitch;
    mix_micro[frame][frame_motors[frame]][2] = yaw;
    frame_motors[frame]++;
  endtask

  // work out the motor commands of one control cycle
  task automatic mix_motors(input ctrl_item_t it);
    int         n;
    int         m;
    int         peak;
    int         v;
    longint     yaw;
    longint     lim;
    longint     acc;
    longint     t;
    int         sums [MOTORS_MAX];
    motor_cmd_t c;
    if (sh_frame >= FRAME_COUNT) begin
      return;
    end
    n = frame_motors[sh_frame];
    if (n > MOTORS_MAX) begin
      n = MOTORS_MAX;
    end
    yaw = longint'(it.yaw);
    if (n > 3) begin
      lim = longint'(it.ycmd);
      lim = 100 + ((lim < 0) ? -lim : lim);
      if (yaw < -lim) begin
        yaw = -lim;
      end else if (yaw > lim) begin
        yaw = lim;
      end
    end
    if (sh_yaw_rev) begin
      yaw = -yaw;
    end
    for (m = 0; m < n; m++) begin
      acc = longint'(it.throttle) * to_fixed(U)
          + longint'(it.roll) * to_fixed(mix_micro[sh_frame][m][0])
          + longint'(it.pitch) * to_fixed(mix_micro[sh_frame][m][1])
          + yaw * to_fixed(mix_micro[sh_frame][m][2]);
      // truncate toward zero, then saturate to the scratch width
      t = (acc < 0) ? -((-acc) >>> FRAC) : (acc >>> FRAC);
      if (t > SUM_MAX) begin
        t = SUM_MAX;
      end
      if (t < SUM_MIN) begin
        t = SUM_MIN;
      end
      sums[m] = int'(t);
    end
    peak = sums[0];
    for (m = 1; m < n; m++) begin
      if (sums[m] > peak) begin
        peak = sums[m];
      end
    end
    for (m = 0; m < n; m++) begin
      v = sums[m];
      if (peak > sh_max_thr) begin
        v -= peak - sh_max_thr;
      end
      if (v < sh_min_thr) begin
        v = sh_min_thr;
      end else if (v > sh_max_thr) begin
        v = sh_max_thr;
      end
      if (int'(it.stick) < sh_min_check) begin
        v = sh_stop ? sh_min_cmd : sh_min_thr;
      end
      if (!it.armed) begin
        v = sh_min_cmd;
      end
      c.index = m[IDX_OUT_W-1:0];
      c.value = v[VAL_W-1:0];
      c.last  = (m == n - 1);
      expected_motor_cmds.push_back(c);
    end
  endtask

  function automatic int pick_gap(input bit on, input int pct);
    if (!on || $urandom_range(0, 99) >= pct) begin
      return 0;
    end
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  // input side: present the backlog, predict on every accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_loaded = 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        mix_motors(tx_cur);
        items_in++;
        tx_loaded = 1'b0;
        tx_gap = pick_gap(tx_idle_on, 40);
      end
      if (!tx_loaded) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (ctrl_backlog.size() > 0) begin
          tx_cur = ctrl_backlog.pop_front();
          tx_loaded = 1'b1;
          throttle_cmd_i   <= tx_cur.throttle;
          pid_roll_i       <= tx_cur.roll;
          pid_pitch_i      <= tx_cur.pitch;
          pid_yaw_i        <= tx_cur.yaw;
          yaw_cmd_i        <= tx_cur.ycmd;
          stick_throttle_i <= tx_cur.stick;
          armed_i          <= tx_cur.armed;
          in_valid_i       <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_motor();
    motor_cmd_t want;
    results_seen++;
    if (expected_motor_cmds.size() == 0) begin
      report_mismatch($sformatf("unexpected motor %0d value %0d", motor_index_o,
                                motor_value_o));
      return;
    end
    want = expected_motor_cmds.pop_front();
    if (motor_index_o !== want.index) begin
      report_mismatch($sformatf("motor_index %0d, want %0d", motor_index_o, want.index));
    end
    if (motor_value_o !== want.value) begin
      report_mismatch($sformatf("motor %0d value %0d, want %0d", want.index,
                                motor_value_o, want.value));
    end
    if (last_o !== want.last) begin
      report_mismatch($sformatf("motor %0d last %b, want %b", want.index, last_o,
                                want.last));
    end
  endtask

  // output side: check accepted results, apply back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_motor();
      end
      if (hold_requests > holds_served) begin
        rx_hold = LONG_HOLD;
        holds_served++;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else begin
        rx_hold = pick_gap(rx_idle_on, 20);
        out_stall_i <= (rx_hold > 0);
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_FRAME_TYPE:   sh_frame = val & 15;
      CFG_YAW_REVERSE:  sh_yaw_rev = val[0];
      CFG_MIN_THROTTLE: sh_min_thr = val & 12'hFFF;
      CFG_MAX_THROTTLE: sh_max_thr = val & 12'hFFF;
      CFG_MIN_COMMAND:  sh_min_cmd = val & 12'hFFF;
      CFG_MIN_CHECK:    sh_min_check = val & 12'hFFF;
      CFG_MOTOR_STOP:   sh_stop = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input int frame, input int yaw_rev, input int min_thr,
                            input int max_thr, input int min_cmd, input int min_check,
                            input int stop);
    write_reg(CFG_FRAME_TYPE, frame);
    write_reg(CFG_YAW_REVERSE, yaw_rev);
    write_reg(CFG_MIN_THROTTLE, min_thr);
    write_reg(CFG_MAX_THROTTLE, max_thr);
    write_reg(CFG_MIN_COMMAND, min_cmd);
    write_reg(CFG_MIN_CHECK, min_check);
    write_reg(CFG_MOTOR_STOP, stop);
    settings_run++;
  endtask

  task automatic push_item(input int thr, input int roll, input int pitch, input int yaw,
                           input int ycmd, input int stick, input int armed);
    ctrl_item_t it;
    it.throttle = thr[IN_W-1:0];
    it.roll     = roll[IN_W-1:0];
    it.pitch    = pitch[IN_W-1:0];
    it.yaw      = yaw[IN_W-1:0];
    it.ycmd     = ycmd[IN_W-1:0];
    it.stick    = stick[STICK_W-1:0];
    it.armed    = armed[0];
    ctrl_backlog.push_back(it);
  endtask

  // mostly flight-like cycles, the rest anywhere in the field ranges
  task automatic push_random(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        push_item(1000 + int'($urandom_range(0, 1000)), int'($urandom_range(0, 1200)) - 600,
                  int'($urandom_range(0, 1200)) - 600, int'($urandom_range(0, 1000)) - 500,
                  int'($urandom_range(0, 600)) - 300, int'($urandom_range(1000, 2000)),
                  ($urandom_range(0, 19) != 0));
      end else begin
        push_item(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()),
                  int'($urandom()), int'($urandom()), int'($urandom()));
      end
    end
  endtask

  // hold until every item is in, every result out, and the pipe has drained
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (ctrl_backlog.size() != 0 || tx_loaded || expected_motor_cmds.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    add_motor(0, 0, P43, 0);   add_motor(0, -U, N23, 0);  add_motor(0, U, N23, 0);
    add_motor(1, 0, U, -U);    add_motor(1, -U, 0, U);    add_motor(1, U, 0, U);
    add_motor(1, 0, -U, -U);
    add_motor(2, -U, U, -U);   add_motor(2, -U, -U, U);   add_motor(2, U, U, U);
    add_motor(2, U, -U, -U);
    add_motor(3, U, 0, 0);     add_motor(3, -U, 0, 0);
    add_motor(4, 0, P43, U);   add_motor(4, -U, N23, -U); add_motor(4, U, N23, -U);
    add_motor(4, 0, P43, -U);  add_motor(4, -U, N23, U);  add_motor(4, U, N23, U);
    add_motor(5, -U, S32, U);  add_motor(5, -U, -S32, -U); add_motor(5, U, S32, U);
    add_motor(5, U, -S32, -U); add_motor(5, 0, S32, U);   add_motor(5, 0, -S32, -U);
    add_motor(6, 0, U, -U);    add_motor(6, -U, -U, 0);   add_motor(6, 0, U, U);
    add_motor(6, U, -U, 0);
    add_motor(7, -S32, U, U);  add_motor(7, -S32, -U, U); add_motor(7, S32, U, -U);
    add_motor(7, S32, -U, -U); add_motor(7, -S32, 0, -U); add_motor(7, S32, 0, U);
    add_motor(8, -U, U, -U);   add_motor(8, -U, -U, U);   add_motor(8, U, U, U);
    add_motor(8, U, -U, -U);   add_motor(8, -U, U, U);    add_motor(8, -U, -U, -U);
    add_motor(8, U, U, -U);    add_motor(8, U, -U, U);
    add_motor(9, R22, -R22, U);  add_motor(9, -R22, -R22, U);
    add_motor(9, -R22, R22, U);  add_motor(9, R22, R22, U);
    add_motor(9, 0, -U, -U);     add_motor(9, -U, 0, -U);
    add_motor(9, 0, U, -U);      add_motor(9, U, 0, -U);
    add_motor(10, U, -HF, U);    add_motor(10, -HF, -U, U);
    add_motor(10, -U, HF, U);    add_motor(10, HF, U, U);
    add_motor(10, HF, -U, -U);   add_motor(10, -U, -HF, -U);
    add_motor(10, -HF, U, -U);   add_motor(10, U, HF, -U);
    add_motor(11, 0, U, U);    add_motor(11, -U, -U, 0);  add_motor(11, 0, U, -U);
    add_motor(11, U, -U, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: quad x
    push_item(0, 0, 0, 0, 0, 0, 0);
    push_item(1500, 0, 0, 0, 0, 1500, 1);
    push_item(1500, 200, -150, 0, 0, 1500, 1);
    push_item(1800, 300, 200, 0, 0, 2000, 1);          // shift down from max throttle
    push_item(1000, 0, 0, 0, 0, 2000, 1);              // lifted to min throttle
    push_item(1500, 0, 0, 5000, 0, 1500, 1);           // yaw clamped to 100
    push_item(1500, 0, 0, -5000, -300, 1500, 1);       // window widened by yaw command
    push_item(1500, 0, 0, -32768, -32768, 1500, 1);    // widest window
    push_item(32767, 32767, 32767, 32767, 32767, 4095, 1);
    push_item(-32768, -32768, -32768, -32768, -32768, 4095, 1);
    push_item(-32768, 32767, -32768, 32767, 0, 4095, 1);
    push_item(1500, 0, 0, 0, 0, 1099, 1);              // low stick idles
    push_item(1500, 0, 0, 0, 0, 1100, 1);
    push_item(1500, 100, 100, 100, 0, 1099, 0);        // disarm beats low stick
    push_item(1500, -1, -1, -1, -1, 0, 1);
    push_item(21845, -21846, 21845, -21846, 21845, 2730, 1);
    push_item(-21846, 21845, -21846, 21845, -21846, 1365, 1);
    push_item(2000, -600, 600, 400, 50, 1500, 1);
    settings_run++;
    wait_idle();

    set_config(0, 1, 1150, 1850, 1000, 1100, 0);
    push_item(1500, 0, 0, -32768, 0, 1500, 1);         // no yaw clamp on three motors
    push_item(1500, 0, 0, 20000, 0, 1500, 1);
    push_random(4);
    wait_idle();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_config(1, 0, 0, 4095, 0, 0, 1);
    push_item(32767, 32767, 32767, 32767, 32767, 0, 1);
    push_random(7);
    wait_idle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    set_config(3, 1, 1900, 1200, 4095, 1500, 1);       // min throttle above max
    push_item(1500, 0, 0, -32768, 0, 2000, 1);
    push_item(1500, 0, 0, 0, 0, 1499, 1);
    push_random(7);
    wait_idle();

    set_config(4, 0, 1100, 1900, 900, 1050, 0);
    push_random(7);
    wait_idle();

    set_config(5, 1, 4095, 4095, 0, 4095, 1);
    push_random(6);
    wait_idle();

    set_config(6, 0, 0, 0, 4095, 4095, 0);
    push_random(6);
    wait_idle();

    // hold the output off while the input keeps coming
    tx_idle_on = 1'b0;
    set_config(7, 1, 1150, 1850, 1000, 1100, 0);
    hold_requests++;
    push_random(6);
    wait_idle();

    set_config(8, 0, 1150, 1850, 1000, 1100, 1);
    hold_requests++;
    push_random(10);
    wait_idle();
    tx_idle_on = 1'b1;

    set_config(9, 1, 1000, 2000, 950, 1050, 1);
    push_random(5);
    wait_idle();

    set_config(10, 0, 1200, 1800, 1000, 1100, 0);
    push_random(5);
    wait_idle();

    set_config(11, 1, 1150, 1850, 1000, 1100, 0);
    push_random(7);
    wait_idle();

    // unknown frame: no motors at all
    set_config(13, 0, 1150, 1850, 1000, 1100, 0);
    push_random(4);
    wait_idle();

    repeat (3) begin
      set_config($urandom_range(0, FRAME_COUNT - 1), $urandom_range(0, 1),
                 $urandom_range(900, 1300), $urandom_range(1600, 2100),
                 $urandom_range(800, 1100), $urandom_range(1000, 1200), $urandom_range(0, 1));
      push_random(3);
      wait_idle();
    end

    set_config(15, 1, 1150, 1850, 1000, 1100, 1);
    push_random(2);
    wait_idle();

    $display("Mixed %0d control cycles under %0d register settings, %0d motor results checked.",
             items_in, settings_run, results_seen);
    $display("All twelve frames, unknown frames and %0d long output hold-offs exercised.",
             holds_served);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
